FILE: rtl/core/rth_pkg.sv
// rth_pkg: shared types and constants for the rgb to hsv converter
// holds channel widths, the pipeline stage record and the hue sector codes
// no dependencies
package rth_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_W      = 16;
  localparam int DEG_W      = 9;
  localparam int X17_W      = 13;
  localparam int NUM_STAGES = 12;

  // stage map: 0 min/max, 1 numerators, 2..9 divider steps, 10 degrees, 11 hue scale
  localparam int DIV_FIRST  = 2;
  localparam int DIV_STEPS  = 8;
  localparam int DEG_STAGE  = DIV_FIRST + DIV_STEPS;
  localparam int HUE_STAGE  = DEG_STAGE + 1;

  localparam logic [DEG_W-1:0] OFF_RED_POS = 9'd0;
  localparam logic [DEG_W-1:0] OFF_RED_NEG = 9'd360;
  localparam logic [DEG_W-1:0] OFF_GREEN   = 9'd120;
  localparam logic [DEG_W-1:0] OFF_BLUE    = 9'd240;

  localparam logic [NUM_W-1:0] RECIP3      = 16'd683;  // 2^11 / 3 rounded up

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  delta;
    logic [CH_W-1:0]  diff;
    logic             neg;
    sector_e          sector;
    logic             zero_d;
    logic [NUM_W-1:0] rem_h;
    logic [CH_W-1:0]  q_h;
    logic [NUM_W-1:0] rem_s;
    logic [CH_W-1:0]  q_s;
    logic [X17_W-1:0] deg_x17;
    logic [CH_W-1:0]  hue;
  } stage_t;

endpackage

FILE: rtl/core/rth_rgb_if.sv
// rth_rgb_if: valid/ready channel carrying one rgb pixel per transaction
// depends on rth_pkg for the channel width
interface rth_rgb_if;
  logic                   valid;
  logic                   ready;
  logic [rth_pkg::CH_W-1:0] red;
  logic [rth_pkg::CH_W-1:0] green;
  logic [rth_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/rth_hsv_if.sv
// rth_hsv_if: valid/ready channel carrying one hsv pixel per transaction
// depends on rth_pkg for the channel width
interface rth_hsv_if;
  logic                   valid;
  logic                   ready;
  logic [rth_pkg::CH_W-1:0] hue;
  logic [rth_pkg::CH_W-1:0] saturation;
  logic [rth_pkg::CH_W-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: rtl/core/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: pipelined 8-bit rgb to hsv conversion
// depends on rth_pkg, rth_rgb_if and rth_hsv_if
// throughput: one pixel per cycle while the output is taken; two restoring dividers
//   each retire one quotient bit per stage over eight stages, every stage holds its
//   own valid bit
// stalls fill bubbles first; a full pipeline holds until the output is taken
// reset (rst_ni low, asynchronous) clears all stage valid bits, no other state
module rgb_to_hsv_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  rth_rgb_if.sink   rgb_i,
  rth_hsv_if.source hsv_o
);
  import rth_pkg::*;

  stage_t               stg_q [NUM_STAGES];
  stage_t               stg_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] v_q, v_d;
  logic [NUM_STAGES:0]   rdy;
  stage_t               front;

  // front end: max, min, sector and signed difference
  always_comb begin
    logic [CH_W-1:0] r, g, b, mx, mn;
    r = rgb_i.red;
    g = rgb_i.green;
    b = rgb_i.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    front        = '0;
    front.mx     = mx;
    front.delta  = mx - mn;
    front.zero_d = (mx == mn);
    if (r == mx) begin
      front.sector = SEC_RED;
      front.neg    = (g < b);
      front.diff   = (g >= b) ? g - b : b - g;
    end else if (g == mx) begin
      front.sector = SEC_GREEN;
      front.neg    = (b < r);
      front.diff   = (b >= r) ? b - r : r - b;
    end else begin
      front.sector = SEC_BLUE;
      front.neg    = (r < g);
      front.diff   = (r >= g) ? r - g : g - r;
    end
  end

  always_comb begin
    logic [NUM_W-1:0] d16, diff16, dvs_h, dvs_s;
    logic [DEG_W-1:0] off, deg;
    logic [9:0]       x3;
    logic [19:0]      prod;

    stg_d[0] = front;

    // numerators: 60*|diff| for hue, 255*delta for saturation
    stg_d[1]       = stg_q[0];
    d16            = NUM_W'(stg_q[0].delta);
    diff16         = NUM_W'(stg_q[0].diff);
    stg_d[1].rem_h = (diff16 << 6) - (diff16 << 2);
    stg_d[1].rem_s = (d16 << 8) - d16;
    stg_d[1].q_h   = '0;
    stg_d[1].q_s   = '0;

    // one restoring division step per stage, msb first
    for (int i = DIV_FIRST; i < DEG_STAGE; i++) begin
      stg_d[i] = stg_q[i-1];
      dvs_h = NUM_W'(stg_q[i-1].delta) << (DEG_STAGE - 1 - i);
      dvs_s = NUM_W'(stg_q[i-1].mx) << (DEG_STAGE - 1 - i);
      if (stg_q[i-1].rem_h >= dvs_h) begin
        stg_d[i].rem_h = stg_q[i-1].rem_h - dvs_h;
        stg_d[i].q_h   = stg_q[i-1].q_h | CH_W'(1 << (DEG_STAGE - 1 - i));
      end
      if (stg_q[i-1].rem_s >= dvs_s) begin
        stg_d[i].rem_s = stg_q[i-1].rem_s - dvs_s;
        stg_d[i].q_s   = stg_q[i-1].q_s | CH_W'(1 << (DEG_STAGE - 1 - i));
      end
    end

    // degrees from sector offset; a negative term rounds toward minus infinity
    stg_d[DEG_STAGE] = stg_q[DEG_STAGE-1];
    case (stg_q[DEG_STAGE-1].sector)
      SEC_RED:   off = stg_q[DEG_STAGE-1].neg ? OFF_RED_NEG : OFF_RED_POS;
      SEC_GREEN: off = OFF_GREEN;
      SEC_BLUE:  off = OFF_BLUE;
      default:   off = OFF_RED_POS;
    endcase
    if (stg_q[DEG_STAGE-1].zero_d) begin
      deg = '0;
    end else if (stg_q[DEG_STAGE-1].neg) begin
      deg = off - DEG_W'(stg_q[DEG_STAGE-1].q_h)
                - DEG_W'(stg_q[DEG_STAGE-1].rem_h != '0);
    end else begin
      deg = off + DEG_W'(stg_q[DEG_STAGE-1].q_h);
    end
    // deg*255/360 = deg*17/24
    stg_d[DEG_STAGE].deg_x17 = (X17_W'(deg) << 4) + X17_W'(deg);
    if (stg_q[DEG_STAGE-1].zero_d) stg_d[DEG_STAGE].q_s = '0;

    // divide by 24: shift by 3, then reciprocal multiply for the 3
    stg_d[HUE_STAGE] = stg_q[HUE_STAGE-1];
    x3   = stg_q[HUE_STAGE-1].deg_x17[X17_W-1:3];
    prod = 20'(x3) * 20'(RECIP3);
    stg_d[HUE_STAGE].hue = prod[18:11];
  end

  // a stage can load when it is empty or its content moves on
  always_comb begin
    rdy[NUM_STAGES] = hsv_o.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
    if (rdy[0]) v_d[0] = rgb_i.valid;
    else        v_d[0] = v_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) v_d[i] = v_q[i-1];
      else        v_d[i] = v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (rdy[i]) stg_q[i] <= stg_d[i];
    end
  end

  assign rgb_i.ready      = rdy[0];
  assign hsv_o.valid      = v_q[NUM_STAGES-1];
  assign hsv_o.hue        = stg_q[NUM_STAGES-1].hue;
  assign hsv_o.saturation = stg_q[NUM_STAGES-1].q_s;
  assign hsv_o.value      = stg_q[NUM_STAGES-1].mx;

endmodule

FILE: rtl/core/rth_checker.sv
// rth_checker: port-level assertions for rgb_to_hsv_converter, attached by bind
// depends on rth_pkg; sees only the top level's ports
module rth_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [rth_pkg::CH_W-1:0] red_i,
  input logic [rth_pkg::CH_W-1:0] green_i,
  input logic [rth_pkg::CH_W-1:0] blue_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [rth_pkg::CH_W-1:0] hue_i,
  input logic [rth_pkg::CH_W-1:0] saturation_i,
  input logic [rth_pkg::CH_W-1:0] value_i
);
  import rth_pkg::*;

  localparam int LAT = NUM_STAGES;

  logic [3:0]      ready_run_q;
  logic            in_acc;
  logic [CH_W-1:0] mx_in;

  assign in_acc = in_valid_i && in_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_run_q <= '0;
    end else if (!out_ready_i) begin
      ready_run_q <= '0;
    end else if (ready_run_q != 4'(LAT - 1)) begin
      ready_run_q <= ready_run_q + 4'd1;
    end
  end

  always_comb begin
    mx_in = red_i;
    if (green_i > mx_in) mx_in = green_i;
    if (blue_i > mx_in)  mx_in = blue_i;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i)
      && $stable(saturation_i) && $stable(value_i))
    else $error("output transaction changed while stalled");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && value_i == '0 |-> saturation_i == '0 && hue_i == '0)
    else $error("black pixel with nonzero hue or saturation");

  // with the output always taken, a pixel comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc, LAT) && $past(rst_ni, LAT) && ready_run_q == 4'(LAT - 1)
      |-> out_valid_i && value_i == $past(mx_in, LAT))
    else $error("pixel missing or wrong value after pipeline latency");

endmodule

bind rgb_to_hsv_converter rth_checker u_rth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (rgb_i.valid),
  .in_ready_i   (rgb_i.ready),
  .red_i        (rgb_i.red),
  .green_i      (rgb_i.green),
  .blue_i       (rgb_i.blue),
  .out_valid_i  (hsv_o.valid),
  .out_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .value_i      (hsv_o.value)
);
